### sv/top_k_unique_sorted_table_assert.svh
// assertion macros for the top-k table checker
`ifndef TOP_K_UNIQUE_SORTED_TABLE_ASSERT_SVH
`define TOP_K_UNIQUE_SORTED_TABLE_ASSERT_SVH

// same-cycle implication
`define TKUS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkus assertion failed");

// next-cycle implication
`define TKUS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkus assertion failed");

`endif

### sv/tkus_pkg.sv
package tkus_pkg;

    localparam int TABLE_SIZE_DEF = 16;
    localparam int VALUE_W        = 31;
    localparam int RANK_W         = 6;
    localparam int COUNT_W        = 7;
    localparam int STATUS_W       = 3;
    localparam int OPCODE_W       = 2;
    localparam int IN_VALUE_W     = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_READ   = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_NONPOS   = 3'd1,
        ST_TOOLOW   = 3'd2,
        ST_DUP      = 3'd3,
        ST_CLEARED  = 3'd4,
        ST_ENTRY    = 3'd5,
        ST_EMPTY    = 3'd6
    } t_status;

    typedef struct packed {
        logic insert;
        logic rotate;
    } t_cell_ctl;

    typedef struct packed {
        logic              dup;
        logic [RANK_W-1:0] dup_rank;
        logic [RANK_W-1:0] ins_rank;
        logic              tail_free;
    } t_chain_stat;

endpackage

### sv/tkus_cell.sv
module tkus_cell #(
    parameter int IDX = 0,
    parameter int CW  = 5
) (
    input  logic                           i_clk,
    input  tkus_pkg::t_cell_ctl            i_ctl,
    input  logic [CW-1:0]                  i_count,
    input  logic [tkus_pkg::VALUE_W-1:0]   i_raw,
    input  logic [tkus_pkg::VALUE_W-1:0]   i_left_val,
    input  logic                           i_left_a,
    input  logic [tkus_pkg::VALUE_W-1:0]   i_right_val,
    input  logic [tkus_pkg::VALUE_W-1:0]   i_head_val,
    output logic [tkus_pkg::VALUE_W-1:0]   o_val,
    output logic                           o_a,
    output logic                           o_eq
);

    logic [tkus_pkg::VALUE_W-1:0] r_val;
    logic [tkus_pkg::VALUE_W-1:0] n_val;
    logic                         w_valid;
    logic                         w_tail;

    assign w_valid = CW'(IDX) < i_count;
    assign w_tail  = CW'(IDX + 1) == i_count;

    // a: new value belongs at or above this slot
    assign o_a  = !w_valid || (r_val < i_raw);
    assign o_eq = w_valid && (r_val == i_raw);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.insert) begin
            if (i_left_a) begin
                n_val = i_left_val;
            end else if (o_a) begin
                n_val = i_raw;
            end
        end else if (i_ctl.rotate) begin
            n_val = w_tail ? i_head_val : i_right_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

endmodule

### sv/tkus_chain.sv
module tkus_chain #(
    parameter int TABLE_SIZE = tkus_pkg::TABLE_SIZE_DEF,
    parameter int CW         = 5
) (
    input  logic                           i_clk,
    input  tkus_pkg::t_cell_ctl            i_ctl,
    input  logic [CW-1:0]                  i_count,
    input  logic [tkus_pkg::VALUE_W-1:0]   i_raw,
    output logic [tkus_pkg::VALUE_W-1:0]   o_head_val,
    output tkus_pkg::t_chain_stat          o_stat
);

    logic [tkus_pkg::VALUE_W-1:0] w_val [TABLE_SIZE];
    logic [TABLE_SIZE-1:0]        w_a;
    logic [TABLE_SIZE-1:0]        w_eq;
    logic [TABLE_SIZE-1:0]        w_bnd;

    for (genvar g = 0; g < TABLE_SIZE; g++) begin : g_cell
        logic [tkus_pkg::VALUE_W-1:0] w_left_val;
        logic                         w_left_a;
        logic [tkus_pkg::VALUE_W-1:0] w_right_val;

        if (g == 0) begin : g_first
            assign w_left_val = w_val[0];
            assign w_left_a   = 1'b0;
            assign w_bnd[g]   = w_a[g];
        end else begin : g_rest
            assign w_left_val = w_val[g-1];
            assign w_left_a   = w_a[g-1];
            assign w_bnd[g]   = w_a[g] && !w_a[g-1];
        end

        if (g == TABLE_SIZE - 1) begin : g_last
            assign w_right_val = w_val[0];
        end else begin : g_mid
            assign w_right_val = w_val[g+1];
        end

        tkus_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (i_ctl),
            .i_count     (i_count),
            .i_raw       (i_raw),
            .i_left_val  (w_left_val),
            .i_left_a    (w_left_a),
            .i_right_val (w_right_val),
            .i_head_val  (w_val[0]),
            .o_val       (w_val[g]),
            .o_a         (w_a[g]),
            .o_eq        (w_eq[g])
        );
    end

    assign o_head_val = w_val[0];

    always_comb begin
        o_stat           = '0;
        o_stat.dup       = |w_eq;
        o_stat.tail_free = w_a[TABLE_SIZE-1];
        for (int i = 0; i < TABLE_SIZE; i++) begin
            if (w_eq[i]) begin
                o_stat.dup_rank = o_stat.dup_rank | tkus_pkg::RANK_W'(i);
            end
            if (w_bnd[i]) begin
                o_stat.ins_rank = o_stat.ins_rank | tkus_pkg::RANK_W'(i);
            end
        end
    end

endmodule

### sv/top_k_unique_sorted_table.sv
// Top-K table of distinct positive values kept in descending order in a row of
// cells, one value per cell. Insert, clear, and a read of an empty table can follow
// one another every cycle while the output is not stalled. A read of n entries holds
// the input stalled while the chain rotates one cell per cycle, pausing while the
// output is stalled, and cell 0 feeds the single output register. The table is
// empty after reset.
module top_k_unique_sorted_table #(
    parameter int TABLE_SIZE = tkus_pkg::TABLE_SIZE_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [tkus_pkg::OPCODE_W-1:0]     i_opcode,
    input  logic signed [tkus_pkg::IN_VALUE_W-1:0] i_value,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [tkus_pkg::STATUS_W-1:0]     o_status,
    output logic [tkus_pkg::RANK_W-1:0]       o_rank,
    output logic [tkus_pkg::VALUE_W-1:0]      o_entry_value,
    output logic [tkus_pkg::COUNT_W-1:0]      o_count,
    output logic                              o_last
);

    localparam int CW = $clog2(TABLE_SIZE + 1);
    localparam int IW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state                          r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [IW-1:0]                   r_rd_idx, n_rd_idx;
    logic                            r_o_valid, n_o_valid;
    tkus_pkg::t_status               r_status, n_status;
    logic [tkus_pkg::RANK_W-1:0]     r_rank, n_rank;
    logic [tkus_pkg::VALUE_W-1:0]    r_entry, n_entry;
    logic [CW-1:0]                   r_o_count, n_o_count;
    logic                            r_last, n_last;

    tkus_pkg::t_cell_ctl             w_ctl;
    tkus_pkg::t_chain_stat           w_stat;
    logic [tkus_pkg::VALUE_W-1:0]    w_head;
    logic                            w_load_ok;
    logic                            w_accept;
    logic                            w_full;
    logic                            w_rd_last;
    logic                            w_load;

    assign w_load_ok  = !r_o_valid || !i_out_stall;
    assign o_in_stall = (r_state == S_READ) || !w_load_ok;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_full     = r_count == CW'(TABLE_SIZE);
    assign w_rd_last  = (CW'(r_rd_idx) + CW'(1)) == r_count;

    tkus_chain #(
        .TABLE_SIZE (TABLE_SIZE),
        .CW         (CW)
    ) u_chain (
        .i_clk      (i_clk),
        .i_ctl      (w_ctl),
        .i_count    (r_count),
        .i_raw      (i_value[tkus_pkg::VALUE_W-1:0]),
        .o_head_val (w_head),
        .o_stat     (w_stat)
    );

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_rd_idx  = r_rd_idx;
        n_o_valid = r_o_valid && i_out_stall;
        n_status  = r_status;
        n_rank    = r_rank;
        n_entry   = r_entry;
        n_o_count = r_o_count;
        n_last    = r_last;
        w_ctl     = '0;
        w_load    = 1'b0;

        if (w_accept) begin
            n_rank    = '0;
            n_entry   = '0;
            n_o_count = r_count;
            n_last    = 1'b1;
            unique case (tkus_pkg::t_opcode'(i_opcode))
                tkus_pkg::OP_INSERT: begin
                    w_load = 1'b1;
                    priority if (i_value == '0 || i_value[tkus_pkg::IN_VALUE_W-1]) begin
                        n_status = tkus_pkg::ST_NONPOS;
                    end else if (w_full && !w_stat.tail_free) begin
                        n_status = tkus_pkg::ST_TOOLOW;
                    end else if (w_stat.dup) begin
                        n_status = tkus_pkg::ST_DUP;
                        n_rank   = w_stat.dup_rank;
                    end else begin
                        n_status     = tkus_pkg::ST_INSERTED;
                        n_rank       = w_stat.ins_rank;
                        w_ctl.insert = 1'b1;
                        if (!w_full) begin
                            n_count   = r_count + CW'(1);
                            n_o_count = r_count + CW'(1);
                        end
                    end
                end
                tkus_pkg::OP_CLEAR: begin
                    w_load    = 1'b1;
                    n_status  = tkus_pkg::ST_CLEARED;
                    n_count   = '0;
                    n_o_count = '0;
                end
                tkus_pkg::OP_READ: begin
                    if (r_count == '0) begin
                        w_load   = 1'b1;
                        n_status = tkus_pkg::ST_EMPTY;
                    end else begin
                        n_state  = S_READ;
                        n_rd_idx = '0;
                    end
                end
                default: begin
                end
            endcase
        end else if (r_state == S_READ && w_load_ok) begin
            w_load       = 1'b1;
            w_ctl.rotate = 1'b1;
            n_status     = tkus_pkg::ST_ENTRY;
            n_rank       = tkus_pkg::RANK_W'(r_rd_idx);
            n_entry      = w_head;
            n_o_count    = r_count;
            n_last       = w_rd_last;
            n_rd_idx     = r_rd_idx + IW'(1);
            if (w_rd_last) begin
                n_state = S_IDLE;
            end
        end

        if (w_load) begin
            n_o_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_rd_idx  <= n_rd_idx;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status  <= n_status;
        r_rank    <= n_rank;
        r_entry   <= n_entry;
        r_o_count <= n_o_count;
        r_last    <= n_last;
    end

    assign o_out_valid   = r_o_valid;
    assign o_status      = r_status;
    assign o_rank        = r_rank;
    assign o_entry_value = r_entry;
    assign o_count       = tkus_pkg::COUNT_W'(r_o_count);
    assign o_last        = r_last;

endmodule

### sv/tkus_checker.sv
`include "top_k_unique_sorted_table_assert.svh"

module tkus_checker #(
    parameter int TABLE_SIZE = tkus_pkg::TABLE_SIZE_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [tkus_pkg::STATUS_W-1:0]  o_status,
    input logic [tkus_pkg::RANK_W-1:0]    o_rank,
    input logic [tkus_pkg::VALUE_W-1:0]   o_entry_value,
    input logic [tkus_pkg::COUNT_W-1:0]   o_count,
    input logic                           o_last
);

    localparam int PAYLOAD_W = tkus_pkg::STATUS_W + tkus_pkg::RANK_W + tkus_pkg::VALUE_W
                             + tkus_pkg::COUNT_W + 1;

    logic                 w_is_entry;
    logic                 w_rank_last;
    logic                 w_held;
    logic [PAYLOAD_W-1:0] w_payload;
    logic                 w_count_ok;
    logic                 w_single_ok;
    logic                 w_rank_ok;

    assign w_is_entry  = o_status == tkus_pkg::ST_ENTRY;
    assign w_rank_last = ({1'b0, o_rank} + tkus_pkg::COUNT_W'(1)) == o_count;
    assign w_held      = o_out_valid && i_out_stall;
    assign w_payload   = {o_status, o_rank, o_entry_value, o_count, o_last};
    assign w_count_ok  = o_count <= tkus_pkg::COUNT_W'(TABLE_SIZE);
    assign w_single_ok = o_last && (o_entry_value == '0);
    assign w_rank_ok   = ({1'b0, o_rank} < o_count) && (o_last == w_rank_last);

    // stalled transaction holds
    `TKUS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_held, o_out_valid && $stable(w_payload))

    `TKUS_ASSERT_NOW(a_count_max, i_clk, i_rst_n, o_out_valid, w_count_ok)

    // only readout carries a value, everything else is a single final transaction
    `TKUS_ASSERT_NOW(a_single_result, i_clk, i_rst_n, o_out_valid && !w_is_entry, w_single_ok)

    // readout rank stays in range and last marks the final rank
    `TKUS_ASSERT_NOW(a_entry_rank, i_clk, i_rst_n, o_out_valid && w_is_entry, w_rank_ok)

endmodule

bind top_k_unique_sorted_table tkus_checker #(
    .TABLE_SIZE (TABLE_SIZE)
) u_tkus_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_status      (o_status),
    .o_rank        (o_rank),
    .o_entry_value (o_entry_value),
    .o_count       (o_count),
    .o_last        (o_last)
);

### bench/tb.sv
module tb;
    import tkus_pkg::*;

    localparam int TBL_DEPTH = TABLE_SIZE_DEF;
    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int TAIL_CYCLES = 2 * TBL_DEPTH + 8;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [RANK_W-1:0]   rank;
        logic [VALUE_W-1:0]  val;
        logic [COUNT_W-1:0]  count;
        logic                last;
    } t_result;

    typedef struct packed {
        logic [OPCODE_W-1:0]   op;
        logic [IN_VALUE_W-1:0] val;
        logic                  typed;
        t_result               want;
    } t_dir_row;

    logic                         i_clk;
    logic                         i_rst_n = 1'b0;
    logic                         i_in_valid = 1'b0;
    logic                         o_in_stall;
    logic [OPCODE_W-1:0]          i_opcode = OP_INSERT;
    logic signed [IN_VALUE_W-1:0] i_value = '0;
    logic                         o_out_valid;
    logic                         i_out_stall = 1'b0;
    logic [STATUS_W-1:0]          o_status;
    logic [RANK_W-1:0]            o_rank;
    logic [VALUE_W-1:0]           o_entry_value;
    logic [COUNT_W-1:0]           o_count;
    logic                         o_last;

    logic drv_typed = 1'b0;
    t_result drv_want = '0;

    int snd_idle_pct = 22;
    int rcv_idle_pct = 78;
    int phase = 0;
    logic rcv_hold = 1'b0;
    int fail_cnt = 0;

    logic [VALUE_W-1:0] top_vals [TBL_DEPTH];
    int top_cnt = 0;
    t_result step_results[$];
    t_result pending_results[$];

    t_dir_row dir_rows [0:25] = '{
        '{OP_READ,   32'd0,          1'b1, '{ST_EMPTY,    6'd0, 31'd0, 7'd0,  1'b1}},
        '{OP_INSERT, 32'd0,          1'b1, '{ST_NONPOS,   6'd0, 31'd0, 7'd0,  1'b1}},
        '{OP_INSERT, 32'h8000_0000,  1'b1, '{ST_NONPOS,   6'd0, 31'd0, 7'd0,  1'b1}},
        '{OP_INSERT, 32'hffff_ffff,  1'b1, '{ST_NONPOS,   6'd0, 31'd0, 7'd0,  1'b1}},
        '{OP_UNUSED, 32'h5a5a_5a5a,  1'b0, '0},
        '{OP_CLEAR,  32'h1234_5678,  1'b1, '{ST_CLEARED,  6'd0, 31'd0, 7'd0,  1'b1}},
        '{OP_INSERT, 32'h7fff_ffff,  1'b1, '{ST_INSERTED, 6'd0, 31'd0, 7'd1,  1'b1}},
        '{OP_INSERT, 32'd500,        1'b0, '0},
        '{OP_INSERT, 32'd100,        1'b0, '0},
        '{OP_INSERT, 32'd900,        1'b0, '0},
        '{OP_INSERT, 32'd300,        1'b0, '0},
        '{OP_INSERT, 32'd700,        1'b0, '0},
        '{OP_INSERT, 32'd200,        1'b0, '0},
        '{OP_INSERT, 32'd800,        1'b0, '0},
        '{OP_INSERT, 32'd400,        1'b0, '0},
        '{OP_INSERT, 32'd600,        1'b0, '0},
        '{OP_INSERT, 32'd150,        1'b0, '0},
        '{OP_INSERT, 32'd50,         1'b0, '0},
        '{OP_INSERT, 32'd950,        1'b0, '0},
        '{OP_INSERT, 32'd250,        1'b0, '0},
        '{OP_INSERT, 32'd1000,       1'b0, '0},
        '{OP_INSERT, 32'd20,         1'b0, '0},
        '{OP_INSERT, 32'd20,         1'b1, '{ST_TOOLOW,   6'd0, 31'd0, 7'd16, 1'b1}},
        '{OP_INSERT, 32'h7fff_ffff,  1'b1, '{ST_DUP,      6'd0, 31'd0, 7'd16, 1'b1}},
        '{OP_INSERT, 32'd25,         1'b0, '0},
        '{OP_READ,   32'hdead_beef,  1'b0, '0}
    };

    top_k_unique_sorted_table #(
        .TABLE_SIZE(TBL_DEPTH)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_rank        (o_rank),
        .o_entry_value (o_entry_value),
        .o_count       (o_count),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= REPORT_MAX) begin
            $display("%s", msg);
        end
    endfunction

    function automatic void add_result(input logic [STATUS_W-1:0] st, input int rank,
                                       input logic [VALUE_W-1:0] v, input int cnt,
                                       input logic lst);
        t_result r;
        r.status = st;
        r.rank   = rank[RANK_W-1:0];
        r.val    = v;
        r.count  = cnt[COUNT_W-1:0];
        r.last   = lst;
        step_results = {step_results, r};
    endfunction

    function automatic void top_table_update(input logic [OPCODE_W-1:0] op,
                                             input logic signed [IN_VALUE_W-1:0] v);
        logic [VALUE_W-1:0] uv;
        int hit;
        int pos;
        int i;
        step_results.delete();
        uv = v[VALUE_W-1:0];
        case (op)
            OP_INSERT: begin
                if (v <= 0) begin
                    add_result(ST_NONPOS, 0, '0, top_cnt, 1'b1);
                end else if (top_cnt == TBL_DEPTH && uv <= top_vals[TBL_DEPTH-1]) begin
                    add_result(ST_TOOLOW, 0, '0, top_cnt, 1'b1);
                end else begin
                    hit = -1;
                    for (i = 0; i < top_cnt; i++) begin
                        if (hit < 0 && top_vals[i] == uv) hit = i;
                    end
                    if (hit >= 0) begin
                        add_result(ST_DUP, hit, '0, top_cnt, 1'b1);
                    end else begin
                        pos = top_cnt;
                        for (i = top_cnt - 1; i >= 0; i--) begin
                            if (top_vals[i] < uv) pos = i;
                        end
                        if (top_cnt < TBL_DEPTH) top_cnt++;
                        for (i = top_cnt - 1; i > pos; i--) begin
                            top_vals[i] = top_vals[i-1];
                        end
                        top_vals[pos] = uv;
                        add_result(ST_INSERTED, pos, '0, top_cnt, 1'b1);
                    end
                end
            end
            OP_CLEAR: begin
                top_cnt = 0;
                add_result(ST_CLEARED, 0, '0, 0, 1'b1);
            end
            OP_READ: begin
                if (top_cnt == 0) begin
                    add_result(ST_EMPTY, 0, '0, 0, 1'b1);
                end else begin
                    for (i = 0; i < top_cnt; i++) begin
                        add_result(ST_ENTRY, i, top_vals[i], top_cnt, i == top_cnt - 1);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // result check first, then the transaction accepted at the same edge
    always @(posedge i_clk) begin : scoreboard
        t_result seen;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen.status = o_status;
                seen.rank   = o_rank;
                seen.val    = o_entry_value;
                seen.count  = o_count;
                seen.last   = o_last;
                if (pending_results.size() == 0) begin
                    note_fail($sformatf({"unexpected result: status %0d rank %0d",
                                         " value %0d count %0d last %0d"},
                                        seen.status, seen.rank, seen.val, seen.count,
                                        seen.last));
                end else begin
                    want = pending_results.pop_front();
                    if (seen.status !== want.status || seen.rank !== want.rank ||
                        seen.val !== want.val || seen.count !== want.count ||
                        seen.last !== want.last) begin
                        note_fail($sformatf({"mismatch: expected status %0d rank %0d value %0d",
                                             " count %0d last %0d, got status %0d rank %0d",
                                             " value %0d count %0d last %0d"},
                                            want.status, want.rank, want.val, want.count,
                                            want.last, seen.status, seen.rank, seen.val,
                                            seen.count, seen.last));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                top_table_update(i_opcode, i_value);
                if (drv_typed) begin
                    pending_results = {pending_results, drv_want};
                end else begin
                    pending_results = {pending_results, step_results};
                end
            end
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= rcv_hold || ($urandom_range(99) < rcv_idle_pct);
    end

    // long output hold while the sender keeps offering
    initial begin
        wait (phase == 2);
        repeat (5) @(negedge i_clk);
        rcv_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        rcv_hold <= 1'b0;
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) quiet = 0;
            else quiet++;
        end
        $display("top_k_unique_sorted_table regression: fail");
        $finish;
    end

    // entered and left at a falling edge
    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [IN_VALUE_W-1:0] v,
                             input logic typed, input t_result want);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_value    <= v;
        drv_typed  <= typed;
        drv_want   <= want;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int n);
        int issued;
        int pick;
        logic [OPCODE_W-1:0] op;
        logic [IN_VALUE_W-1:0] v;
        issued = 0;
        while (issued < n) begin
            pick = $urandom_range(99);
            v = $urandom;
            if (pick < 80) begin
                op = OP_INSERT;
                pick = $urandom_range(99);
                // small values give duplicates, a full table and evictions
                if (pick < 60) v = $urandom_range(60, 1);
                else if (pick < 75) v = {1'b0, v[30:0]};
                else if (pick >= 88) begin
                    case ($urandom_range(4))
                        0: v = 32'd0;
                        1: v = 32'd1;
                        2: v = 32'h7fff_ffff;
                        3: v = 32'h8000_0000;
                        default: v = 32'hffff_ffff;
                    endcase
                end
            end else if (pick < 92) begin
                op = OP_READ;
            end else if (pick < 96) begin
                op = OP_CLEAR;
            end else begin
                op = OP_UNUSED;
            end
            if (op != OP_UNUSED) issued++;
            send_item(op, v, 1'b0, '0);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            send_item(dir_rows[r].op, dir_rows[r].val, dir_rows[r].typed, dir_rows[r].want);
        end
        send_random(32);
        drain_results();

        snd_idle_pct = 78;
        rcv_idle_pct = 22;
        phase = 1;
        send_random(32);
        drain_results();

        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        phase = 2;
        send_random(32);
        drain_results();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        foreach (pending_results[k]) begin
            note_fail($sformatf("missing result: status %0d rank %0d value %0d count %0d",
                                pending_results[k].status, pending_results[k].rank,
                                pending_results[k].val, pending_results[k].count));
        end
        if (fail_cnt == 0) begin
            $display("top_k_unique_sorted_table regression: pass");
        end else begin
            $display("top_k_unique_sorted_table regression: fail");
        end
        $finish;
    end
endmodule
